>>> rtl/utlf_pkg.sv
`default_nettype none

package utlf_pkg;

    // Group and history sizes.
    localparam int SAMPLES_PER_READING = 5;
    localparam int HISTORY_DEPTH       = 3;

    // Field widths.
    localparam int ECHO_W  = 20;
    localparam int LEVEL_W = 7;
    localparam int HEIGHT_W = 10;

    // Running sum of one group and the divider operand widths.
    localparam int SUM_W   = $clog2(SAMPLES_PER_READING * (2 ** ECHO_W - 1) + 1);
    localparam int DIST_MUL = 17;
    localparam int DIV_W   = SUM_W + 5;
    localparam int DIVR_W  = HEIGHT_W;

    // Distance in hundredths is floor(sum * 17 / (10 * samples)), formed as
    // floor(sum * DIST_RECIP / 2**DIST_SHIFT). The shift is large enough that
    // the rounding of the reciprocal never reaches the next integer for any
    // sum that a full group can produce.
    localparam longint SUM_MAX    = longint'(SAMPLES_PER_READING) *
                                    ((longint'(1) << ECHO_W) - 1);
    localparam longint DIST_DIV   = 10 * SAMPLES_PER_READING;
    localparam int     DIST_SHIFT = $clog2(SUM_MAX * DIST_DIV + 1);
    localparam longint DIST_RECIP = ((longint'(DIST_MUL) << DIST_SHIFT) + DIST_DIV - 1) /
                                    DIST_DIV;
    localparam int     RECIP_W    = $clog2(DIST_RECIP + 1);
    localparam int     PROD_W     = SUM_W + RECIP_W;

    // Sample counter, history fill count and history total.
    localparam int SMP_W = $clog2(SAMPLES_PER_READING + 1);
    localparam int VS_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int TOT_W = $clog2(HISTORY_DEPTH * 100 + 1);

    // Distance window in hundredths of a centimeter and level limits.
    localparam int MIN_DIST_HUND = 200;
    localparam int MAX_DIST_HUND = 40000;
    localparam int PCT_FULL      = 100;
    localparam int HEIGHT_SCALE  = 100;

    // Configuration register word addresses.
    localparam logic REG_EMPTY = 1'b0;
    localparam logic REG_FULL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_GO,
        ST_CHECK,
        ST_LEVEL_WAIT,
        ST_PUSH,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/utlf_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is valid in
// the cycle that o_done is high.
module utlf_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [utlf_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [utlf_pkg::DIVR_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [utlf_pkg::DIV_W-1:0]       o_quotient
);

    localparam int CNT_W = $clog2(utlf_pkg::DIV_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [utlf_pkg::DIVR_W-1:0] r_rem;
    logic [utlf_pkg::DIVR_W-1:0] r_dvs;
    logic [utlf_pkg::DIV_W-1:0]  r_quo;

    logic [utlf_pkg::DIVR_W:0]   w_trial;
    logic [utlf_pkg::DIVR_W:0]   w_diff;
    logic                        w_bit;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        w_trial = {r_rem, r_quo[utlf_pkg::DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_bit   = (w_trial >= {1'b0, r_dvs});
    end

    // Control: busy flag, step counter and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(utlf_pkg::DIV_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(utlf_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: the dividend shifts out at the top as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[utlf_pkg::DIVR_W-1:0] : w_trial[utlf_pkg::DIVR_W-1:0];
            r_quo <= {r_quo[utlf_pkg::DIV_W-2:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> rtl/ultrasonic_tank_level_filter.sv
`default_nettype none

// Ultrasonic tank level filter.
// Input channel (i_in_valid, o_in_stall, i_echo_us) carries one echo duration
// in microseconds per transaction. Every fifth transaction closes a group: the
// group sum is turned into a distance, the distance into a fill level, and the
// level is averaged with the history. Each closed group gives one transaction
// on the output channel (o_out_valid, i_out_stall, o_level_pct,
// o_reading_error); other samples give none.
// A sample that does not close a group leaves the sequencer idle and the
// input unstalled. After a closing sample the distance comes from a
// reciprocal multiply, and the shared bit-serial divider then makes up to two
// passes (level, mean): both when the surface lies above empty, the mean pass
// only when it lies beyond empty, none on an error. o_in_stall stays high
// until the result is loaded into the output register.
// The result sits in an output register; while it waits, new samples are still
// taken, and only the next closed group waits for the register to free up.
// The APB port writes empty_height at 0x0 and full_height at 0x4; the user
// must write them only while idle, as the block does not enforce it. Reset
// clears the group sum, sample count, history, fill count, heights and o_out_valid.
module ultrasonic_tank_level_filter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [utlf_pkg::ECHO_W-1:0]   i_echo_us,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [utlf_pkg::LEVEL_W-1:0]       o_level_pct,
    output logic                               o_reading_error,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    utlf_pkg::t_state r_state;
    utlf_pkg::t_state n_state;

    logic [utlf_pkg::HEIGHT_W-1:0] r_empty;
    logic [utlf_pkg::HEIGHT_W-1:0] r_full;
    logic [utlf_pkg::SUM_W-1:0]    r_sum;
    logic [utlf_pkg::SMP_W-1:0]    r_count;
    logic [utlf_pkg::DIV_W-1:0]    r_dist;
    logic [utlf_pkg::LEVEL_W-1:0]  r_level;
    logic [utlf_pkg::LEVEL_W-1:0]  r_hist [utlf_pkg::HISTORY_DEPTH];
    logic [utlf_pkg::VS_W-1:0]     r_valid_seen;
    logic [utlf_pkg::LEVEL_W-1:0]  r_res_level;
    logic                          r_res_err;
    logic                          r_out_valid;
    logic [utlf_pkg::LEVEL_W-1:0]  r_out_level;
    logic                          r_out_err;

    logic                          w_in_accept;
    logic                          w_group_end;
    logic                          w_cfg_write;
    logic                          w_err;
    logic                          w_top_le_dist;
    logic [utlf_pkg::DIV_W-1:0]    w_top;
    logic [utlf_pkg::TOT_W-1:0]    w_total;
    logic [utlf_pkg::PROD_W-1:0]   w_dist_prod;
    logic                          w_div_start;
    logic [utlf_pkg::DIV_W-1:0]    w_div_dividend;
    logic [utlf_pkg::DIVR_W-1:0]   w_div_divisor;
    logic                          w_div_done;
    logic [utlf_pkg::DIV_W-1:0]    w_div_quotient;
    logic                          w_out_load;

    // Shared divider.
    utlf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

    // Configuration registers.
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= '0;
            r_full  <= '0;
        end else if (w_cfg_write) begin
            case (paddr[2])
                utlf_pkg::REG_EMPTY: r_empty <= pwdata[utlf_pkg::HEIGHT_W-1:0];
                utlf_pkg::REG_FULL:  r_full  <= pwdata[utlf_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            utlf_pkg::REG_EMPTY: prdata = {{(32 - utlf_pkg::HEIGHT_W){1'b0}}, r_empty};
            utlf_pkg::REG_FULL:  prdata = {{(32 - utlf_pkg::HEIGHT_W){1'b0}}, r_full};
            default:             prdata = '0;
        endcase
    end

    // Group sum times the distance reciprocal; the top bits are the distance.
    assign w_dist_prod = utlf_pkg::PROD_W'(r_sum) * utlf_pkg::PROD_W'(utlf_pkg::DIST_RECIP);

    // Range checks on the distance and the heights, and the empty level scale.
    always_comb begin
        w_top         = utlf_pkg::DIV_W'(r_empty) * utlf_pkg::DIV_W'(utlf_pkg::HEIGHT_SCALE);
        w_top_le_dist = (w_top <= r_dist);
        w_err         = (r_dist <= utlf_pkg::DIV_W'(utlf_pkg::MIN_DIST_HUND)) ||
                        (r_dist >  utlf_pkg::DIV_W'(utlf_pkg::MAX_DIST_HUND)) ||
                        (r_empty <= r_full);
    end

    // Total of the valid history entries.
    always_comb begin
        w_total = '0;
        for (int i = 0; i < utlf_pkg::HISTORY_DEPTH; i++) begin
            if (utlf_pkg::VS_W'(i) < r_valid_seen) begin
                w_total = w_total + utlf_pkg::TOT_W'(r_hist[i]);
            end
        end
    end

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_group_end = (r_count == utlf_pkg::SMP_W'(utlf_pkg::SAMPLES_PER_READING - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            utlf_pkg::ST_IDLE: begin
                if (w_in_accept && w_group_end) begin
                    n_state = utlf_pkg::ST_DIST_GO;
                end
            end
            utlf_pkg::ST_DIST_GO: n_state = utlf_pkg::ST_CHECK;
            utlf_pkg::ST_CHECK: begin
                if (w_err) begin
                    n_state = utlf_pkg::ST_OUT;
                end else if (w_top_le_dist) begin
                    n_state = utlf_pkg::ST_PUSH;
                end else begin
                    n_state = utlf_pkg::ST_LEVEL_WAIT;
                end
            end
            utlf_pkg::ST_LEVEL_WAIT: begin
                if (w_div_done) begin
                    n_state = utlf_pkg::ST_PUSH;
                end
            end
            utlf_pkg::ST_PUSH:    n_state = utlf_pkg::ST_MEAN_GO;
            utlf_pkg::ST_MEAN_GO: n_state = utlf_pkg::ST_MEAN_WAIT;
            utlf_pkg::ST_MEAN_WAIT: begin
                if (w_div_done) begin
                    n_state = utlf_pkg::ST_OUT;
                end
            end
            utlf_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = utlf_pkg::ST_IDLE;
                end
            end
            default: n_state = utlf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input stall, divider start and operands, output load.
    always_comb begin
        o_in_stall     = 1'b1;
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        w_out_load     = 1'b0;
        case (r_state)
            utlf_pkg::ST_IDLE: o_in_stall = 1'b0;
            utlf_pkg::ST_CHECK: begin
                w_div_start    = !w_err && !w_top_le_dist;
                w_div_dividend = w_top - r_dist;
                w_div_divisor  = r_empty - r_full;
            end
            utlf_pkg::ST_MEAN_GO: begin
                w_div_start    = 1'b1;
                w_div_dividend = utlf_pkg::DIV_W'(w_total);
                w_div_divisor  = utlf_pkg::DIVR_W'(r_valid_seen);
            end
            utlf_pkg::ST_OUT: w_out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utlf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Group accumulation; the sum is cleared once the distance is taken from it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (w_in_accept) begin
            r_sum   <= r_sum + utlf_pkg::SUM_W'(i_echo_us);
            r_count <= w_group_end ? '0 : r_count + 1'b1;
        end else if (r_state == utlf_pkg::ST_DIST_GO) begin
            r_sum <= '0;
        end
    end

    // Distance, clamped level and the result held for the output register.
    always_ff @(posedge i_clk) begin
        if (r_state == utlf_pkg::ST_DIST_GO) begin
            r_dist <= utlf_pkg::DIV_W'(w_dist_prod[utlf_pkg::PROD_W-1:utlf_pkg::DIST_SHIFT]);
        end
        if (r_state == utlf_pkg::ST_CHECK) begin
            r_level <= '0;
            if (w_err) begin
                r_res_level <= r_hist[0];
                r_res_err   <= 1'b1;
            end
        end
        if (r_state == utlf_pkg::ST_LEVEL_WAIT && w_div_done) begin
            r_level <= (w_div_quotient > utlf_pkg::DIV_W'(utlf_pkg::PCT_FULL)) ?
                       utlf_pkg::LEVEL_W'(utlf_pkg::PCT_FULL) :
                       w_div_quotient[utlf_pkg::LEVEL_W-1:0];
        end
        if (r_state == utlf_pkg::ST_MEAN_WAIT && w_div_done) begin
            r_res_level <= w_div_quotient[utlf_pkg::LEVEL_W-1:0];
            r_res_err   <= 1'b0;
        end
    end

    // Level history, newest first, and its saturating fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < utlf_pkg::HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_valid_seen <= '0;
        end else if (r_state == utlf_pkg::ST_PUSH) begin
            for (int i = utlf_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= r_level;
            if (r_valid_seen < utlf_pkg::VS_W'(utlf_pkg::HISTORY_DEPTH)) begin
                r_valid_seen <= r_valid_seen + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_level <= r_res_level;
            r_out_err   <= r_res_err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level_pct     = r_out_level;
    assign o_reading_error = r_out_err;

    // Checks.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level_pct <= utlf_pkg::LEVEL_W'(utlf_pkg::PCT_FULL)))
        else $error("level above full scale");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < utlf_pkg::SMP_W'(utlf_pkg::SAMPLES_PER_READING))
        else $error("sample count past group size");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_seen <= utlf_pkg::VS_W'(utlf_pkg::HISTORY_DEPTH))
        else $error("history fill count past depth");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == utlf_pkg::ST_LEVEL_WAIT ||
                        r_state == utlf_pkg::ST_MEAN_WAIT))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire
